/* hdl/hrbd_pkg.sv */
package hrbd_pkg;

	localparam int COUNT_BITS_DEF = 24;
	localparam int BYTE_W         = 8;
	localparam int LIMIT_W        = 24;
	localparam int BCOUNT_W       = 24;
	localparam int IN_TDATA_W     = 8;
	localparam int OUT_TDATA_W    = 40;

	localparam logic [LIMIT_W-1:0] LIMIT_RST = {LIMIT_W{1'b1}};

	typedef enum logic [2:0] {
		M_HDR   = 3'd0,
		M_CSIZE = 3'd1,
		M_CDATA = 3'd2,
		M_TRAIL = 3'd3,
		M_LEN   = 3'd4,
		M_STRM  = 3'd5,
		M_DONE  = 3'd6
	} mode_t;

	typedef struct packed {
		logic                body_valid;
		logic [BYTE_W-1:0]   body_byte;
		logic                body_done;
		logic [BCOUNT_W-1:0] body_count;
		logic                overflow;
	} res_t;

endpackage

/* hdl/hrbd_core.sv */
module hrbd_core #(
	parameter int COUNT_BITS = hrbd_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [hrbd_pkg::BYTE_W-1:0]   rx_byte,
	input  logic                          stream_end,
	input  logic [hrbd_pkg::LIMIT_W-1:0]  body_limit,
	output hrbd_pkg::res_t                res
);

	localparam int CW = (COUNT_BITS > hrbd_pkg::LIMIT_W) ? COUNT_BITS : hrbd_pkg::LIMIT_W;
	localparam int AW = COUNT_BITS + 4;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [4:0] TE_LEN = 5'd18;
	localparam logic [4:0] CH_LEN = 5'd7;
	localparam logic [4:0] CL_LEN = 5'd16;
	localparam logic [8*18-1:0] TE_PAT = "Transfer-Encoding:";
	localparam logic [8*18-1:0] CH_PAT = 144'("chunked");
	localparam logic [8*18-1:0] CL_PAT = 144'("Content-Length: ");

	localparam logic [7:0] CH_CR  = 8'h0d;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;

	// patterns are held with their first character highest
	function automatic logic [4:0] match_step(input logic [8*18-1:0] pat,
			input logic [4:0] len, input logic [4:0] pos, input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (pos >= len) begin
			r = pos;
		end else if (b == pat[8*(int'(len) - 1 - int'(pos)) +: 8]) begin
			r = pos + 5'd1;
		end else if (b == pat[8*(int'(len) - 1) +: 8]) begin
			r = 5'd1;
		end
		return r;
	endfunction

	hrbd_pkg::mode_t mode_q, mode_d;
	logic                  saw_cr_q, saw_cr_d;
	logic                  line_empty_q, line_empty_d;
	logic [4:0]            te_q, te_d;
	logic [2:0]            ch_q, ch_d;
	logic [4:0]            cl_q, cl_d;
	logic [2:0]            flags_q, flags_d;
	logic                  chunked_q, chunked_d;
	logic                  known_q, known_d;
	logic [COUNT_BITS-1:0] decl_q, decl_d;
	logic [COUNT_BITS-1:0] cr_q, cr_d;
	logic [COUNT_BITS-1:0] dc_q, dc_d;
	logic                  ovf_q, ovf_d;

	logic                  is_cr, is_lf, is_blank, is_dec, is_hex;
	logic [3:0]            dig;
	logic                  le_any, le_empty;
	logic                  lb_empty, lb_cr;
	logic [4:0]            te_nx, ch_nx, cl_nx;
	logic [AW-1:0]         acc_w;
	logic                  acc_sat;
	logic [COUNT_BITS-1:0] acc_v;
	logic [COUNT_BITS-1:0] dc_inc;
	logic                  del_ovf;
	logic [COUNT_BITS-1:0] cr_dec;
	logic                  decl_big;
	logic [CW-1:0]         dc_ext;

	always_comb begin
		is_cr    = rx_byte == CH_CR;
		is_lf    = rx_byte == CH_LF;
		is_blank = (rx_byte == CH_SP) || (rx_byte == CH_TAB);
		is_dec   = (rx_byte >= "0") && (rx_byte <= "9");
		is_hex   = 1'b1;
		dig      = 4'd0;
		if (is_dec) begin
			dig = 4'(rx_byte - 8'("0"));
		end else if ((rx_byte >= "a") && (rx_byte <= "f")) begin
			dig = 4'(rx_byte - 8'("a") + 8'd10);
		end else if ((rx_byte >= "A") && (rx_byte <= "F")) begin
			dig = 4'(rx_byte - 8'("A") + 8'd10);
		end else begin
			is_hex = 1'b0;
		end
	end

	// CRLF line splitter
	always_comb begin
		le_any   = is_lf && saw_cr_q;
		le_empty = le_any && line_empty_q;
		if (le_any) begin
			lb_empty = 1'b1;
			lb_cr    = 1'b0;
		end else begin
			lb_empty = (saw_cr_q || !is_cr) ? 1'b0 : line_empty_q;
			lb_cr    = is_cr;
		end
	end

	assign te_nx = match_step(TE_PAT, TE_LEN, te_q, rx_byte);
	assign ch_nx = match_step(CH_PAT, CH_LEN, 5'(ch_q), rx_byte);
	assign cl_nx = match_step(CL_PAT, CL_LEN, cl_q, rx_byte);

	// digit accumulate, x10 in the headers and x16 on size lines
	always_comb begin
		if (mode_q == hrbd_pkg::M_CSIZE) begin
			acc_w = {cr_q, dig};
		end else begin
			acc_w = (AW'(cr_q) << 3) + (AW'(cr_q) << 1) + AW'(dig);
		end
		acc_sat = |acc_w[AW-1:COUNT_BITS];
		acc_v   = acc_sat ? CNT_MAX : acc_w[COUNT_BITS-1:0];
	end

	always_comb begin
		dc_inc   = (dc_q == CNT_MAX) ? dc_q : dc_q + COUNT_BITS'(1);
		del_ovf  = (dc_q == CNT_MAX) || (CW'(dc_inc) > CW'(body_limit));
		cr_dec   = (cr_q != '0) ? cr_q - COUNT_BITS'(1) : cr_q;
		decl_big = CW'(decl_q) > CW'(body_limit);
	end

	// next mode
	always_comb begin
		mode_d = mode_q;
		if (fire && (mode_q < hrbd_pkg::M_DONE)) begin
			if (stream_end) begin
				mode_d = hrbd_pkg::M_DONE;
			end else begin
				unique case (mode_q)
					hrbd_pkg::M_HDR: begin
						if (le_empty) begin
							if (chunked_q) begin
								mode_d = hrbd_pkg::M_CSIZE;
							end else if (known_q) begin
								mode_d = (decl_q == '0) ? hrbd_pkg::M_DONE : hrbd_pkg::M_LEN;
							end else begin
								mode_d = hrbd_pkg::M_STRM;
							end
						end
					end
					hrbd_pkg::M_CSIZE: begin
						if (le_any && flags_q[0]) begin
							mode_d = (cr_q == '0) ? hrbd_pkg::M_TRAIL : hrbd_pkg::M_CDATA;
						end
					end
					hrbd_pkg::M_CDATA: begin
						if (cr_dec == '0) begin
							mode_d = hrbd_pkg::M_CSIZE;
						end
					end
					hrbd_pkg::M_TRAIL: begin
						if (le_empty) begin
							mode_d = hrbd_pkg::M_DONE;
						end
					end
					hrbd_pkg::M_LEN: begin
						if (dc_inc >= decl_q) begin
							mode_d = hrbd_pkg::M_DONE;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// datapath and result
	always_comb begin
		saw_cr_d     = saw_cr_q;
		line_empty_d = line_empty_q;
		te_d         = te_q;
		ch_d         = ch_q;
		cl_d         = cl_q;
		flags_d      = flags_q;
		chunked_d    = chunked_q;
		known_d      = known_q;
		decl_d       = decl_q;
		cr_d         = cr_q;
		dc_d         = dc_q;
		ovf_d        = ovf_q;
		res.body_valid = 1'b0;
		res.body_byte  = '0;
		res.body_done  = 1'b0;
		if (fire && (mode_q < hrbd_pkg::M_DONE)) begin
			if (stream_end) begin
				res.body_done = 1'b1;
			end else begin
				unique case (mode_q)
					hrbd_pkg::M_HDR: begin
						saw_cr_d     = lb_cr;
						line_empty_d = lb_empty;
						if (!le_any) begin
							te_d = te_nx;
							if (te_nx >= TE_LEN) flags_d[0] = 1'b1;
							ch_d = ch_nx[2:0];
							if (ch_nx >= CH_LEN) flags_d[1] = 1'b1;
							if (cl_q < CL_LEN) begin
								cl_d = cl_nx;
								if (cl_nx == CL_LEN) cr_d = '0;
							end else if (cl_q == CL_LEN) begin
								if (is_dec) begin
									cr_d       = acc_v;
									ovf_d      = ovf_q | acc_sat;
									flags_d[2] = 1'b1;
								end else if (!(is_blank && !flags_q[2])) begin
									cl_d = CL_LEN + 5'd1;
								end
							end
						end else begin
							if (!le_empty) begin
								if (flags_q[1:0] == 2'b11) chunked_d = 1'b1;
								if (cl_q >= CL_LEN) begin
									decl_d  = cr_q;
									known_d = 1'b1;
								end
							end else if (!chunked_q && known_q) begin
								if (decl_big) ovf_d = 1'b1;
								if (decl_q == '0) res.body_done = 1'b1;
							end
							te_d    = '0;
							ch_d    = '0;
							cl_d    = '0;
							flags_d = '0;
							cr_d    = '0;
						end
					end
					hrbd_pkg::M_CSIZE: begin
						saw_cr_d     = lb_cr;
						line_empty_d = lb_empty;
						if (!le_any) begin
							if (!flags_q[1]) begin
								if (is_hex) begin
									cr_d       = acc_v;
									ovf_d      = ovf_q | acc_sat;
									flags_d[0] = 1'b1;
								end else if (!(is_blank && !flags_q[0])) begin
									flags_d[1] = 1'b1;
								end
							end
						end else begin
							if (!flags_q[0]) cr_d = '0;
							flags_d = '0;
						end
					end
					hrbd_pkg::M_CDATA: begin
						res.body_valid = 1'b1;
						res.body_byte  = rx_byte;
						dc_d           = dc_inc;
						ovf_d          = ovf_q | del_ovf;
						cr_d           = cr_dec;
						if (cr_dec == '0) flags_d = '0;
					end
					hrbd_pkg::M_TRAIL: begin
						saw_cr_d     = lb_cr;
						line_empty_d = lb_empty;
						if (le_empty) res.body_done = 1'b1;
					end
					hrbd_pkg::M_LEN: begin
						res.body_valid = 1'b1;
						res.body_byte  = rx_byte;
						dc_d           = dc_inc;
						ovf_d          = ovf_q | del_ovf;
						if (dc_inc >= decl_q) res.body_done = 1'b1;
					end
					hrbd_pkg::M_STRM: begin
						res.body_valid = 1'b1;
						res.body_byte  = rx_byte;
						dc_d           = dc_inc;
						ovf_d          = ovf_q | del_ovf;
					end
					default: begin
					end
				endcase
			end
		end
		dc_ext         = CW'(dc_d);
		res.body_count = dc_ext[hrbd_pkg::BCOUNT_W-1:0];
		res.overflow   = ovf_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= hrbd_pkg::M_HDR;
			saw_cr_q     <= 1'b0;
			line_empty_q <= 1'b1;
			te_q         <= '0;
			ch_q         <= '0;
			cl_q         <= '0;
			flags_q      <= '0;
			chunked_q    <= 1'b0;
			known_q      <= 1'b0;
			decl_q       <= '0;
			cr_q         <= '0;
			dc_q         <= '0;
			ovf_q        <= 1'b0;
		end else begin
			mode_q       <= mode_d;
			saw_cr_q     <= saw_cr_d;
			line_empty_q <= line_empty_d;
			te_q         <= te_d;
			ch_q         <= ch_d;
			cl_q         <= cl_d;
			flags_q      <= flags_d;
			chunked_q    <= chunked_d;
			known_q      <= known_d;
			decl_q       <= decl_d;
			cr_q         <= cr_d;
			dc_q         <= dc_d;
			ovf_q        <= ovf_d;
		end
	end

endmodule

/* hdl/http_response_body_deframer_top.sv */
// Channel   Dir  Handshake          Word
// s_*       in   s_tvalid/s_tready  tdata rx_byte, tlast stream_end
// m_*       out  m_tvalid/m_tready  tdata body_byte/count/overflow, tlast body_done,
//                                   tuser body_valid
// cfg_*     in   cfg_we             cfg_wdata body_limit
//
// One word in and one word out per cycle while m_tready stays high; each word passes
// the input register, then the parse state and result register.
// Asynchronous active-low reset returns the parser to header mode and body_limit
// to all ones.
// m_tready low while m_tvalid is high holds the result register and, once the input
// register is full, drops s_tready in the same cycle.
module http_response_body_deframer_top #(
	parameter int COUNT_BITS = hrbd_pkg::COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [hrbd_pkg::IN_TDATA_W-1:0]     s_tdata,  // [7:0] rx_byte
	input  logic                                s_tlast,  // stream_end
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [hrbd_pkg::OUT_TDATA_W-1:0]    m_tdata,  // [7:0] body_byte, [31:8] body_count,
	                                                      // [32] overflow, [39:33] zero
	output logic                                m_tlast,  // body_done
	output logic                                m_tuser,  // body_valid
	input  logic                                cfg_we,
	input  logic [hrbd_pkg::LIMIT_W-1:0]        cfg_wdata
);

	logic                             valid_s1;
	logic [hrbd_pkg::BYTE_W-1:0]      byte_s1;
	logic                             end_s1;
	logic                             out_valid_q;
	hrbd_pkg::res_t                   res_q;
	hrbd_pkg::res_t                   res;
	logic [hrbd_pkg::LIMIT_W-1:0]     limit_q;
	logic                             adv;
	logic                             fire;

	assign adv      = !out_valid_q || m_tready;
	assign fire     = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= hrbd_pkg::LIMIT_RST;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (adv) out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata[hrbd_pkg::BYTE_W-1:0];
			end_s1  <= s_tlast;
		end
		if (fire) res_q <= res;
	end

	hrbd_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.rx_byte    (byte_s1),
		.stream_end (end_s1),
		.body_limit (limit_q),
		.res        (res)
	);

	assign m_tvalid = out_valid_q;
	assign m_tlast  = res_q.body_done;
	assign m_tuser  = res_q.body_valid;
	assign m_tdata  = {7'd0, res_q.overflow, res_q.body_count, res_q.body_byte};

endmodule
